FILE: rtl/cpds_pkg.sv
// shared types, constants and helper functions of the cart-pole step unit
`default_nettype none
package cpds_pkg;

  localparam int FracBitsDef   = 24;
  localparam int SemiDef       = 0;
  localparam int TrigItersDef  = 24;
  localparam int NumCfg        = 8;
  localparam int CfgW          = 31;
  localparam int ReduceSteps   = 14;
  localparam int LastPc        = 26;

  localparam logic [47:0] Q30TwoPi  = 48'd6746518852;
  localparam logic signed [35:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [35:0] Q30TwoPiS = 36'sd6746518852;
  localparam logic signed [33:0] Q30Gain   = 34'sd652032874;

  localparam logic signed [31:0] Max32 = 32'sh7fffffff;
  localparam logic signed [31:0] Min32 = 32'sh80000000;

  typedef enum logic [2:0] {
    CFG_PUSH_FORCE, CFG_GRAVITY, CFG_POLE_MASS, CFG_TOTAL_MASS,
    CFG_HALF_LEN, CFG_TIME_STEP, CFG_POS_LIMIT, CFG_ANGLE_LIMIT
  } cfg_idx_e;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_e;

  typedef enum logic [4:0] {
    R_POS, R_VEL, R_ANG, R_RATE, R_S, R_C, R_FORCE, R_G, R_MP, R_MT, R_LEN,
    R_TAU, R_FT, R_T, R_U, R_PML, R_TEMP, R_NUM, R_DEN, R_ALPHA, R_ACC
  } opnd_e;

  typedef struct packed {
    op_e   op;
    opnd_e a;
    opnd_e b;
    opnd_e dst;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIG, ST_ISSUE, ST_MULW, ST_DIVW, ST_DONE
  } st_e;

  typedef enum logic [2:0] {
    CP_IDLE, CP_REDUCE, CP_WRAP, CP_FOLD, CP_ROT, CP_DONE
  } cp_e;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} dv_e;

  function automatic logic signed [31:0] sat33(logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7fffffff) r = Max32;
    else if (v < -33'sh0_80000000) r = Min32;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat64(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7fffffff) r = Max32;
    else if (v < -64'sh80000000) r = Min32;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] atan_q30(logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h3243F6A8;  5'd1: r = 32'h1DAC6705;  5'd2: r = 32'h0FADBAFC;
      5'd3: r = 32'h07F56EA6;  5'd4: r = 32'h03FEAB76;  5'd5: r = 32'h01FFD55B;
      5'd6: r = 32'h00FFFAAA;  5'd7: r = 32'h007FFF55;  5'd8: r = 32'h003FFFEA;
      5'd9: r = 32'h001FFFFD;  5'd10: r = 32'h000FFFFF; 5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF; 5'd13: r = 32'h0001FFFF; 5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF; 5'd16: r = 32'h00003FFF; 5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF; 5'd19: r = 32'h000007FF; 5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF; 5'd22: r = 32'h000000FF; 5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F; 5'd25: r = 32'h0000001F; 5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008; 5'd28: r = 32'h00000004; 5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic uop_t mk(op_e op, opnd_e a, opnd_e b, opnd_e dst);
    uop_t u;
    u.op = op; u.a = a; u.b = b; u.dst = dst;
    return u;
  endfunction

  // dynamics program, integration tail depends on semi-implicit mode
  function automatic uop_t uop_at(logic [4:0] pc, logic semi);
    uop_t u;
    case (pc)
      5'd0:  u = mk(OP_MUL, R_MP, R_LEN, R_PML);
      5'd1:  u = mk(OP_MUL, R_PML, R_RATE, R_T);
      5'd2:  u = mk(OP_MUL, R_T, R_RATE, R_T);
      5'd3:  u = mk(OP_MUL, R_T, R_S, R_T);
      5'd4:  u = mk(OP_ADD, R_FORCE, R_T, R_T);
      5'd5:  u = mk(OP_DIV, R_T, R_MT, R_TEMP);
      5'd6:  u = mk(OP_MUL, R_G, R_S, R_T);
      5'd7:  u = mk(OP_MUL, R_C, R_TEMP, R_U);
      5'd8:  u = mk(OP_SUB, R_T, R_U, R_NUM);
      5'd9:  u = mk(OP_MUL, R_MP, R_C, R_T);
      5'd10: u = mk(OP_MUL, R_T, R_C, R_T);
      5'd11: u = mk(OP_DIV, R_T, R_MT, R_T);
      5'd12: u = mk(OP_SUB, R_FT, R_T, R_T);
      5'd13: u = mk(OP_MUL, R_LEN, R_T, R_DEN);
      5'd14: u = mk(OP_DIV, R_NUM, R_DEN, R_ALPHA);
      5'd15: u = mk(OP_MUL, R_PML, R_ALPHA, R_T);
      5'd16: u = mk(OP_MUL, R_T, R_C, R_T);
      5'd17: u = mk(OP_DIV, R_T, R_MT, R_T);
      5'd18: u = mk(OP_SUB, R_TEMP, R_T, R_ACC);
      5'd19: u = semi ? mk(OP_MUL, R_TAU, R_ACC, R_T) : mk(OP_MUL, R_TAU, R_VEL, R_T);
      5'd20: u = semi ? mk(OP_ADD, R_VEL, R_T, R_VEL) : mk(OP_MUL, R_TAU, R_ACC, R_U);
      5'd21: u = semi ? mk(OP_MUL, R_TAU, R_VEL, R_T) : mk(OP_ADD, R_POS, R_T, R_POS);
      5'd22: u = semi ? mk(OP_ADD, R_POS, R_T, R_POS) : mk(OP_ADD, R_VEL, R_U, R_VEL);
      5'd23: u = semi ? mk(OP_MUL, R_TAU, R_ALPHA, R_T) : mk(OP_MUL, R_TAU, R_RATE, R_T);
      5'd24: u = semi ? mk(OP_ADD, R_RATE, R_T, R_RATE) : mk(OP_MUL, R_TAU, R_ALPHA, R_U);
      5'd25: u = semi ? mk(OP_MUL, R_TAU, R_RATE, R_T) : mk(OP_ADD, R_ANG, R_T, R_ANG);
      5'd26: u = semi ? mk(OP_ADD, R_ANG, R_T, R_ANG) : mk(OP_ADD, R_RATE, R_U, R_RATE);
      default: u = mk(OP_ADD, R_T, R_T, R_T);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cpds_cordic.sv
// iterative angle reduction and rotation-mode cordic for sin and cos
`default_nettype none
module cpds_cordic
  import cpds_pkg::*;
#(
  parameter int FRAC_BITS       = FracBitsDef,
  parameter int TRIG_ITERATIONS = TrigItersDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] angle_i,
  output logic                    done_o,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);
  localparam int Shift = 30 - FRAC_BITS;
  localparam int IW    = $clog2(TRIG_ITERATIONS + 1);

  cp_e phase_q, phase_d;
  logic [47:0]        v_q;
  logic               neg_q, flip_q;
  logic [3:0]         k_q;
  logic [IW-1:0]      i_q;
  logic signed [35:0] z_q;
  logic signed [33:0] x_q, y_q;

  logic [31:0]        ang_mag;
  logic [47:0]        cmp;
  logic signed [35:0] zs, zw, atan_v;
  logic signed [33:0] xf, yf, xs, ys;

  assign ang_mag = angle_i[31] ? 32'(-angle_i) : angle_i;
  assign cmp     = Q30TwoPi << k_q;
  assign zs      = neg_q ? -$signed({1'b0, v_q[34:0]}) : $signed({1'b0, v_q[34:0]});
  assign atan_v  = $signed({4'd0, atan_q30(5'(i_q))});

  always_comb begin
    zw = zs;
    if (zs > Q30Pi) zw = zs - Q30TwoPiS;
    else if (zs < -Q30Pi) zw = zs + Q30TwoPiS;
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      CP_IDLE:   if (start_i) phase_d = CP_REDUCE;
      CP_REDUCE: if (k_q == 4'd0) phase_d = CP_WRAP;
      CP_WRAP:   phase_d = CP_FOLD;
      CP_FOLD:   phase_d = CP_ROT;
      CP_ROT:    if (i_q == IW'(TRIG_ITERATIONS - 1)) phase_d = CP_DONE;
      CP_DONE:   phase_d = CP_IDLE;
      default:   phase_d = CP_IDLE;
    endcase
  end

  always_comb begin
    done_o = (phase_q == CP_DONE);
    xf = flip_q ? -x_q : x_q;
    yf = flip_q ? -y_q : y_q;
    xs = xf >>> Shift;
    ys = yf >>> Shift;
    sin_o = ys[31:0];
    cos_o = xs[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= CP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      CP_IDLE: begin
        v_q   <= 48'(ang_mag) << Shift;
        neg_q <= angle_i[31];
        k_q   <= 4'(ReduceSteps - 1);
      end
      CP_REDUCE: begin
        if (v_q >= cmp) v_q <= v_q - cmp;
        k_q <= k_q - 4'd1;
      end
      CP_WRAP: z_q <= zw;
      CP_FOLD: begin
        x_q    <= Q30Gain;
        y_q    <= '0;
        i_q    <= '0;
        flip_q <= 1'b0;
        if (z_q > Q30HalfPi) begin
          z_q <= z_q - Q30Pi;
          flip_q <= 1'b1;
        end else if (z_q < -Q30HalfPi) begin
          z_q <= z_q + Q30Pi;
          flip_q <= 1'b1;
        end
      end
      CP_ROT: begin
        if (z_q >= 0) begin
          x_q <= x_q - (y_q >>> i_q);
          y_q <= y_q + (x_q >>> i_q);
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + (y_q >>> i_q);
          y_q <= y_q - (x_q >>> i_q);
          z_q <= z_q + atan_v;
        end
        i_q <= i_q + IW'(1);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/cpds_div.sv
// radix-2 restoring fixed-point divider with saturation
`default_nettype none
module cpds_div
  import cpds_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic                    done_o,
  output logic signed [31:0]      q_o
);
  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);

  dv_e state_q, state_d;
  logic [DW-1:0] num_q;
  logic [31:0]   rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q, zero_q, apos_q, aneg_q;

  logic [31:0] a_mag, b_mag;
  logic [32:0] trial;
  logic        fits;

  assign a_mag = a_i[31] ? 32'(-a_i) : a_i;
  assign b_mag = b_i[31] ? 32'(-b_i) : b_i;
  assign trial = {rem_q, num_q[DW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: if (start_i) state_d = (b_i == '0) ? DV_DONE : DV_RUN;
      DV_RUN:  if (cnt_q == '0) state_d = DV_DONE;
      DV_DONE: state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == DV_DONE);
    if (zero_q) begin
      q_o = apos_q ? Max32 : (aneg_q ? Min32 : 32'sd0);
    end else if (neg_q) begin
      q_o = (num_q > DW'(33'h0_80000000)) ? Min32 : 32'(-num_q);
    end else begin
      q_o = (num_q > DW'(32'h7fffffff)) ? Max32 : num_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        num_q  <= DW'(a_mag) << FRAC_BITS;
        rem_q  <= '0;
        den_q  <= b_mag;
        cnt_q  <= CW'(DW - 1);
        neg_q  <= a_i[31] ^ b_i[31];
        zero_q <= (b_i == '0);
        apos_q <= !a_i[31] && (a_i != '0);
        aneg_q <= a_i[31];
      end
      DV_RUN: begin
        rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
        num_q <= {num_q[DW-2:0], fits};
        cnt_q <= cnt_q - CW'(1);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/cart_pole_dynamics_step_unit.sv
// cart-pole dynamics step unit: sequencer, shared multiplier, state and ports
//
// channel   | dir | content
// s_axis    | in  | tdata: four load values, tuser: req_type, push_right
// m_axis    | out | tdata: new state, tuser: terminated, reward
// apb       | cfg | eight 31-bit registers at byte address 4*i
//
// an accepted load request goes to the done state, then to the output register when free
// a step request runs the cordic loop, then the program with four serial divider passes
// each zero divisor skips the divider loop
// reset clears the state to zero and loads the default registers
// a new request is taken only while the sequencer is idle
`default_nettype none
module cart_pole_dynamics_step_unit
  import cpds_pkg::*;
#(
  parameter int FRAC_BITS       = FracBitsDef,
  parameter int SEMI_IMPLICIT   = SemiDef,
  parameter int TRIG_ITERATIONS = TrigItersDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // load_position, load_velocity, load_angle, load_angular_rate
  input  wire logic [127:0]  s_axis_tdata,
  // req_type, push_right
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // cart_position, cart_velocity, pole_angle, pole_angular_rate
  output logic [127:0]       m_axis_tdata,
  // terminated, reward
  output logic [1:0]         m_axis_tuser,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam logic signed [31:0] FourThirds = 32'((64'd4 << FRAC_BITS) / 64'd3);

  st_e state_q, state_d;
  logic [CfgW-1:0] cfg_q [NumCfg];
  logic [4:0] pc_q;
  logic push_q;
  logic signed [31:0] pos_q, vel_q, ang_q, rate_q;
  logic signed [31:0] s_q, c_q, t_q, u_q, pml_q, temp_q, num_q, den_q, alpha_q, acc_q;
  logic signed [63:0] prod_q;
  logic m_valid_q;
  logic [127:0] m_data_q;
  logic [1:0] m_user_q;

  uop_t uop;
  logic signed [31:0] opa, opb, res, force_v, res_alu;
  logic accept, cfg_wr, trig_start, trig_done, div_start, div_done, last_op;
  logic signed [31:0] sin_v, cos_v, quo;
  logic signed [32:0] lim_x, lim_a;
  logic term;

  function automatic logic signed [31:0] pick(opnd_e sel, logic signed [31:0] frc,
      logic signed [31:0] p, logic signed [31:0] v, logic signed [31:0] an,
      logic signed [31:0] r, logic signed [31:0] s, logic signed [31:0] c,
      logic signed [31:0] g, logic signed [31:0] mp, logic signed [31:0] mt,
      logic signed [31:0] ln, logic signed [31:0] tau, logic signed [31:0] t,
      logic signed [31:0] u, logic signed [31:0] pml, logic signed [31:0] tmp,
      logic signed [31:0] nm, logic signed [31:0] dn, logic signed [31:0] al,
      logic signed [31:0] ac);
    logic signed [31:0] o;
    case (sel)
      R_POS: o = p;     R_VEL: o = v;     R_ANG: o = an;    R_RATE: o = r;
      R_S: o = s;       R_C: o = c;       R_FORCE: o = frc; R_G: o = g;
      R_MP: o = mp;     R_MT: o = mt;     R_LEN: o = ln;    R_TAU: o = tau;
      R_FT: o = FourThirds; R_T: o = t;   R_U: o = u;       R_PML: o = pml;
      R_TEMP: o = tmp;  R_NUM: o = nm;    R_DEN: o = dn;    R_ALPHA: o = al;
      R_ACC: o = ac;
      default: o = '0;
    endcase
    return o;
  endfunction

  assign uop     = uop_at(pc_q, SEMI_IMPLICIT != 0);
  assign force_v = push_q ? $signed({1'b0, cfg_q[CFG_PUSH_FORCE]})
                          : -$signed({1'b0, cfg_q[CFG_PUSH_FORCE]});

  always_comb begin
    opa = pick(uop.a, force_v, pos_q, vel_q, ang_q, rate_q, s_q, c_q,
               {1'b0, cfg_q[CFG_GRAVITY]}, {1'b0, cfg_q[CFG_POLE_MASS]},
               {1'b0, cfg_q[CFG_TOTAL_MASS]}, {1'b0, cfg_q[CFG_HALF_LEN]},
               {1'b0, cfg_q[CFG_TIME_STEP]}, t_q, u_q, pml_q, temp_q, num_q,
               den_q, alpha_q, acc_q);
    opb = pick(uop.b, force_v, pos_q, vel_q, ang_q, rate_q, s_q, c_q,
               {1'b0, cfg_q[CFG_GRAVITY]}, {1'b0, cfg_q[CFG_POLE_MASS]},
               {1'b0, cfg_q[CFG_TOTAL_MASS]}, {1'b0, cfg_q[CFG_HALF_LEN]},
               {1'b0, cfg_q[CFG_TIME_STEP]}, t_q, u_q, pml_q, temp_q, num_q,
               den_q, alpha_q, acc_q);
    res_alu = (uop.op == OP_SUB) ? sat33(33'(opa) - 33'(opb)) : sat33(33'(opa) + 33'(opb));
  end

  always_comb begin
    case (state_q)
      ST_MULW: res = sat64(prod_q >>> FRAC_BITS);
      ST_DIVW: res = quo;
      default: res = res_alu;
    endcase
  end

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign cfg_wr  = psel && penable && pwrite;
  assign last_op = (pc_q == 5'(LastPc));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = s_axis_tuser[0] ? ST_DONE : ST_TRIG;
      ST_TRIG: if (trig_done) state_d = ST_ISSUE;
      ST_ISSUE: begin
        case (uop.op)
          OP_MUL:  state_d = ST_MULW;
          OP_DIV:  state_d = ST_DIVW;
          default: if (last_op) state_d = ST_DONE;
        endcase
      end
      ST_MULW: state_d = last_op ? ST_DONE : ST_ISSUE;
      ST_DIVW: if (div_done) state_d = last_op ? ST_DONE : ST_ISSUE;
      ST_DONE: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    trig_start    = accept && !s_axis_tuser[0];
    div_start     = (state_q == ST_ISSUE) && (uop.op == OP_DIV);
    m_axis_tvalid = m_valid_q;
    m_axis_tdata  = m_data_q;
    m_axis_tuser  = m_user_q;
    pready        = 1'b1;
    prdata        = {1'b0, cfg_q[paddr[4:2]]};
    lim_x = $signed({2'b0, cfg_q[CFG_POS_LIMIT]});
    lim_a = $signed({2'b0, cfg_q[CFG_ANGLE_LIMIT]});
    term  = (33'(pos_q) < -lim_x) || (33'(pos_q) > lim_x) ||
            (33'(ang_q) < -lim_a) || (33'(ang_q) > lim_a);
  end

  cpds_cordic #(
    .FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_cordic (
    .clk_i, .rst_ni, .start_i(trig_start), .angle_i(ang_q),
    .done_o(trig_done), .sin_o(sin_v), .cos_o(cos_v)
  );

  cpds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(opa), .b_i(opb),
    .done_o(div_done), .q_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      pc_q      <= '0;
      pos_q <= '0; vel_q <= '0; ang_q <= '0; rate_q <= '0;
      cfg_q[CFG_PUSH_FORCE]  <= 31'd167772160;
      cfg_q[CFG_GRAVITY]     <= 31'd164416717;
      cfg_q[CFG_POLE_MASS]   <= 31'd1677722;
      cfg_q[CFG_TOTAL_MASS]  <= 31'd18454938;
      cfg_q[CFG_HALF_LEN]    <= 31'd8388608;
      cfg_q[CFG_TIME_STEP]   <= 31'd335544;
      cfg_q[CFG_POS_LIMIT]   <= 31'd40265318;
      cfg_q[CFG_ANGLE_LIMIT] <= 31'd3513812;
    end else begin
      state_q <= state_d;
      if (cfg_wr) cfg_q[paddr[4:2]] <= pwdata[30:0];
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == ST_IDLE && accept) begin
        pc_q <= '0;
        if (s_axis_tuser[0]) begin
          pos_q  <= s_axis_tdata[31:0];
          vel_q  <= s_axis_tdata[63:32];
          ang_q  <= s_axis_tdata[95:64];
          rate_q <= s_axis_tdata[127:96];
        end
      end
      if ((state_q == ST_ISSUE && (uop.op == OP_ADD || uop.op == OP_SUB)) ||
          state_q == ST_MULW || (state_q == ST_DIVW && div_done)) begin
        pc_q <= pc_q + 5'd1;
        case (uop.dst)
          R_POS:  pos_q  <= res;
          R_VEL:  vel_q  <= res;
          R_ANG:  ang_q  <= res;
          R_RATE: rate_q <= res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) push_q <= s_axis_tuser[1];
    if (trig_done) begin
      s_q <= sin_v;
      c_q <= cos_v;
    end
    if (state_q == ST_ISSUE) prod_q <= opa * opb;
    if ((state_q == ST_ISSUE && (uop.op == OP_ADD || uop.op == OP_SUB)) ||
        state_q == ST_MULW || (state_q == ST_DIVW && div_done)) begin
      case (uop.dst)
        R_T:     t_q     <= res;
        R_U:     u_q     <= res;
        R_PML:   pml_q   <= res;
        R_TEMP:  temp_q  <= res;
        R_NUM:   num_q   <= res;
        R_DEN:   den_q   <= res;
        R_ALPHA: alpha_q <= res;
        R_ACC:   acc_q   <= res;
        default: ;
      endcase
    end
    if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {rate_q, ang_q, vel_q, pos_q};
      m_user_q <= {!term, term};
    end
  end
endmodule
`default_nettype wire
